// ===== sv/rmmt_pkg.sv =====
// shared types and constants of the range minimum / maximum tree
package rmmt_pkg;

   localparam int VAL_W = 31;
   localparam int IDX_W = 10;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   // operation codes carried in tuser
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // controller states, one-hot
   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_WR_LEAF = 6'b000100,
      ST_WR_UP   = 6'b001000,
      ST_QRY     = 6'b010000,
      ST_QFIN    = 6'b100000
   } rmmt_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_write;
      logic write_leaf;
      logic write_up;
      logic load_query;
      logic query_step;
      logic out_load;
   } rmmt_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_done;
      logic write_ok;
      logic root_reached;
      logic l_lt_r;
   } rmmt_status_type;

endpackage

// ===== sv/rmmt_datapath.sv =====
// node memories, index registers and min / max folding of the tree
module rmmt_datapath #(
   parameter int LEAVES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rmmt_pkg::rmmt_cmd_type          cmd,
   output rmmt_pkg::rmmt_status_type       status,
   input  logic [rmmt_pkg::IDX_W-1:0]      first_index,
   input  logic [rmmt_pkg::IDX_W-1:0]      last_index,
   input  logic [rmmt_pkg::VAL_W-1:0]      value,
   output logic [rmmt_pkg::VAL_W-1:0]      span_min,
   output logic [rmmt_pkg::VAL_W-1:0]      span_max
);

   localparam int LW    = (LEAVES > 1) ? $clog2(LEAVES) : 1;
   localparam int PAD   = 1 << LW;
   localparam int NODES = 2 * PAD;
   localparam int NW    = LW + 1;
   localparam int PW    = NW + 1;
   localparam int VW    = rmmt_pkg::VAL_W;

   // node memories, entry 0 unused, root at 1
   logic [VW-1:0] min_mem [NODES];
   logic [VW-1:0] max_mem [NODES];

   logic [NW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] l_ff, l_in;
   logic [PW-1:0] r_ff, r_in;
   logic [VW-1:0] cur_min_ff, cur_min_in, cur_max_ff, cur_max_in;
   logic [VW-1:0] acc_min_ff, acc_min_in, acc_max_ff, acc_max_in;
   logic [VW-1:0] rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic          ua_ff, ua_in, ub_ff, ub_in;
   logic [VW-1:0] rd_a_min_ff, rd_a_max_ff, rd_b_min_ff, rd_b_max_ff;

   logic          mem_we;
   logic [NW-1:0] waddr, raddr_a, raddr_b;
   logic [VW-1:0] wmin, wmax;
   logic [VW-1:0] par_min, par_max, t_min, t_max, f_min, f_max;
   logic [PW-1:0] parent;
   logic [31:0]   first32, last32, last_c32;
   logic          empty;
   logic          l_lt_r;

   // index range checks and clamping
   always_comb begin
      first32  = {{(32-rmmt_pkg::IDX_W){1'b0}}, first_index};
      last32   = {{(32-rmmt_pkg::IDX_W){1'b0}}, last_index};
      last_c32 = (last32 >= 32'(LEAVES)) ? 32'(LEAVES - 1) : last32;
      empty    = first32 > last_c32;
   end

   assign parent = pos_ff >> 1;
   assign l_lt_r = l_ff < r_ff;

   assign status.clear_done   = clr_cnt_ff == NW'(NODES - 1);
   assign status.write_ok     = first32 < 32'(LEAVES);
   assign status.root_reached = parent == PW'(1);
   assign status.l_lt_r       = l_lt_r;

   // pair min / max for the climb of a write
   assign par_min = (rd_a_min_ff < cur_min_ff) ? rd_a_min_ff : cur_min_ff;
   assign par_max = (rd_a_max_ff > cur_max_ff) ? rd_a_max_ff : cur_max_ff;

   // fold of the boundary nodes read in the previous cycle
   always_comb begin
      t_min = acc_min_ff;
      t_max = acc_max_ff;
      if (ua_ff) begin
         if (rd_a_min_ff < t_min) t_min = rd_a_min_ff;
         if (rd_a_max_ff > t_max) t_max = rd_a_max_ff;
      end
      f_min = t_min;
      f_max = t_max;
      if (ub_ff) begin
         if (rd_b_min_ff < f_min) f_min = rd_b_min_ff;
         if (rd_b_max_ff > f_max) f_max = rd_b_max_ff;
      end
   end

   // memory port selection
   always_comb begin
      mem_we  = 1'b0;
      waddr   = clr_cnt_ff;
      wmin    = rmmt_pkg::VAL_MAX;
      wmax    = '0;
      raddr_a = l_ff[NW-1:0];
      raddr_b = NW'(r_ff - PW'(1));
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.write_leaf) begin
         mem_we  = 1'b1;
         waddr   = pos_ff[NW-1:0];
         wmin    = cur_min_ff;
         wmax    = cur_max_ff;
         raddr_a = pos_ff[NW-1:0] ^ NW'(1);
      end else if (cmd.write_up) begin
         mem_we  = 1'b1;
         waddr   = parent[NW-1:0];
         wmin    = par_min;
         wmax    = par_max;
         raddr_a = parent[NW-1:0] ^ NW'(1);
      end
   end

   // next values of the working registers
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      pos_in     = pos_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      cur_min_in = cur_min_ff;
      cur_max_in = cur_max_ff;
      acc_min_in = f_min;
      acc_max_in = f_max;
      rsp_min_in = rsp_min_ff;
      rsp_max_in = rsp_max_ff;
      ua_in      = 1'b0;
      ub_in      = 1'b0;
      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + NW'(1);
      end
      if (cmd.load_write) begin
         pos_in     = PW'(PAD) + PW'(first_index);
         cur_min_in = value;
         cur_max_in = value;
      end
      if (cmd.write_up) begin
         pos_in     = parent;
         cur_min_in = par_min;
         cur_max_in = par_max;
      end
      if (cmd.load_query) begin
         l_in       = PW'(PAD) + PW'(first_index);
         r_in       = empty ? l_in : (PW'(PAD) + PW'(last_c32) + PW'(1));
         acc_min_in = rmmt_pkg::VAL_MAX;
         acc_max_in = '0;
      end
      if (cmd.query_step && l_lt_r) begin
         ua_in = l_ff[0];
         ub_in = r_ff[0];
         l_in  = (l_ff + PW'(l_ff[0])) >> 1;
         r_in  = r_ff >> 1;
      end
      if (cmd.out_load) begin
         rsp_min_in = acc_min_ff;
         rsp_max_in = acc_max_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         ua_ff      <= 1'b0;
         ub_ff      <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         ua_ff      <= ua_in;
         ub_ff      <= ub_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      cur_min_ff <= cur_min_in;
      cur_max_ff <= cur_max_in;
      acc_min_ff <= acc_min_in;
      acc_max_ff <= acc_max_in;
      rsp_min_ff <= rsp_min_in;
      rsp_max_ff <= rsp_max_in;
   end

   // node memories: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         min_mem[waddr] <= wmin;
         max_mem[waddr] <= wmax;
      end
      rd_a_min_ff <= min_mem[raddr_a];
      rd_a_max_ff <= max_mem[raddr_a];
      rd_b_min_ff <= min_mem[raddr_b];
      rd_b_max_ff <= max_mem[raddr_b];
   end

   assign span_min = rsp_min_ff;
   assign span_max = rsp_max_ff;

endmodule

// ===== sv/rmmt_ctrl.sv =====
// sequencing state machine of the range minimum / maximum tree
module rmmt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_func,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  rmmt_pkg::rmmt_status_type  status,
   output rmmt_pkg::rmmt_cmd_type     cmd
);

   rmmt_pkg::rmmt_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_tready = state_ff == rmmt_pkg::ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         rmmt_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = rmmt_pkg::ST_IDLE;
         end
         rmmt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == rmmt_pkg::FUNC_QUERY) begin
                  cmd.load_query = 1'b1;
                  state_in       = rmmt_pkg::ST_QRY;
               end else if (status.write_ok) begin
                  cmd.load_write = 1'b1;
                  state_in       = rmmt_pkg::ST_WR_LEAF;
               end
            end
         end
         rmmt_pkg::ST_WR_LEAF: begin
            cmd.write_leaf = 1'b1;
            state_in       = rmmt_pkg::ST_WR_UP;
         end
         rmmt_pkg::ST_WR_UP: begin
            cmd.write_up = 1'b1;
            if (status.root_reached) state_in = rmmt_pkg::ST_IDLE;
         end
         rmmt_pkg::ST_QRY: begin
            cmd.query_step = 1'b1;
            if (!status.l_lt_r) state_in = rmmt_pkg::ST_QFIN;
         end
         rmmt_pkg::ST_QFIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = rmmt_pkg::ST_IDLE;
            end
         end
         default: state_in = rmmt_pkg::ST_CLEAR;
      endcase
   end

   // output item held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmmt_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   // a write climb ends at the root and returns to idle
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmmt_pkg::ST_WR_UP && status.root_reached)
      |=> state_ff == rmmt_pkg::ST_IDLE)
      else $error("write climb did not stop at the root");

   // a query only finishes once the range pointers have met
   a_query_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == rmmt_pkg::ST_QFIN |-> !status.l_lt_r)
      else $error("query finished with pointers still apart");

endmodule

// ===== sv/range_min_max_tree_core.sv =====
// Range minimum / maximum tree: top level joining controller and datapath
//
// Input channel (req_): one item per handshake. req_tuser selects the
// operation: 0 writes req value at leaf first_index, 1 queries the
// inclusive leaf range first_index..last_index. A write returns nothing;
// a query returns one item on rsp_ with the range minimum and maximum.
// Writes beyond the leaf count are dropped, a last index beyond it is
// clamped, and an empty range returns minimum all ones and maximum zero.
// Unwritten leaves count as all ones for the minimum and zero for the max.
// Operation: with D = ceil(log2(LEAVES)) tree levels, a write stores the
// leaf and then climbs to the root, one node pair per level through the
// single memory write port; a query climbs one level per cycle through two
// memory read ports, then folds the last boundary nodes read.
// One item is worked on at a time; req_tready is high only when idle.
// Reset: a clearing pass writes all 2 * 2^D node entries, one per cycle,
// before the first item is accepted.
// Stall: the result sits in an output register; the next item is taken
// while it waits, and a later query holds its result until rsp_tready.
module range_min_max_tree_core #(
   parameter int LEAVES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // first_index[9:0], last_index[19:10], value[50:20]
   input  logic        req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // span_min[30:0], span_max[61:31]
);

   rmmt_pkg::rmmt_cmd_type    cmd;
   rmmt_pkg::rmmt_status_type status;
   logic [rmmt_pkg::VAL_W-1:0] span_min, span_max;

   // sequencing
   rmmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // memories and arithmetic
   rmmt_datapath #(
      .LEAVES (LEAVES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .first_index (req_tdata[9:0]),
      .last_index  (req_tdata[19:10]),
      .value       (req_tdata[50:20]),
      .span_min    (span_min),
      .span_max    (span_max)
   );

   assign rsp_tdata = {2'b00, span_max, span_min};

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench of the range minimum / maximum tree core
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = rmmt_pkg::IDX_W;
   localparam int VAL_W = rmmt_pkg::VAL_W;
   localparam logic [VAL_W-1:0] VAL_MAX = rmmt_pkg::VAL_MAX;

   localparam int LEAVES      = 1024;
   localparam int PAD_LEAVES  = 1 << $clog2(LEAVES);
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 750;
   localparam int DIRECTED    = 25;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic             func;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
      logic [VAL_W-1:0] value;
   } tree_op_type;

   typedef struct {
      logic             func;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
      logic [VAL_W-1:0] value;
      bit               typed;
      logic [VAL_W-1:0] want_min;
      logic [VAL_W-1:0] want_max;
   } directed_row_type;

   typedef struct {
      logic [VAL_W-1:0] lo_val;
      logic [VAL_W-1:0] hi_val;
   } extremes_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_BLOCKS} rx_mode_type;

   // clock, reset and block inputs, all known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // first_index[9:0], last_index[19:10], value[50:20]
   logic        req_tuser  = 1'b0; // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // span_min[30:0], span_max[61:31]

   // predictor state: one min tree and one max tree, heap ordered
   logic [VAL_W-1:0] tree_min [1:2*PAD_LEAVES-1];
   logic [VAL_W-1:0] tree_max [1:2*PAD_LEAVES-1];

   extremes_type pending_extremes [$];

   int mismatch_count = 0;
   int n_writes = 0;
   int n_queries = 0;
   int n_empty = 0;
   int n_checked = 0;
   int cycle_count = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_span = 0;
   int          rx_hold = 0;

   // directed table: extremes after reset, corner leaves, empty ranges
   directed_row_type directed_rows [DIRECTED] = '{
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd1023, 31'd0,         1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd1023, 10'd1023, VAL_MAX,       1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd0,    31'd0,         1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd0,    10'd1023, 31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd1023, 10'd0,    VAL_MAX,       1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd1023, 31'd0,         1'b1, 31'd0,   VAL_MAX},
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd0,    31'd0,         1'b1, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd1023, 10'd1023, 31'd0,         1'b1, VAL_MAX, VAL_MAX},
      '{rmmt_pkg::FUNC_QUERY, 10'd1,    10'd1022, 31'd0,         1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd5,    10'd4,    31'd0,         1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd1023, 10'd0,    VAL_MAX,       1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd512,  10'd3,    31'h1234_5678, 1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd511,  10'd1023, 31'h0000_0001, 1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd1,    10'd0,    31'h2AAA_AAAA, 1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd1022, 10'd0,    31'h5555_5555, 1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd1,    10'd1022, 31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd511,  10'd512,  31'h7FFF_0000, 1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd2,    10'd1021, 31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd512,  10'd0,    31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd1023, 31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd3,    10'd3,    31'd0,         1'b1, VAL_MAX, 31'd0},
      '{rmmt_pkg::FUNC_WRITE, 10'd0,    10'd0,    VAL_MAX,       1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd511,  31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd513,  10'd1023, 31'd0,         1'b0, 31'd0,   31'd0},
      '{rmmt_pkg::FUNC_QUERY, 10'd0,    10'd1023, 31'd0,         1'b0, 31'd0,   31'd0}
   };

   range_min_max_tree_core #(
      .LEAVES(LEAVES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // free-running clock
   always #HALF_PERIOD clock = ~clock;

   // leaf store with every ancestor recomputed in both trees
   function automatic void tree_store(input int leaf, input logic [VAL_W-1:0] val);
      int pos;
      pos = PAD_LEAVES + leaf;
      tree_min[pos] = val;
      tree_max[pos] = val;
      pos = pos >> 1;
      while (pos >= 1) begin
         tree_min[pos] = (tree_min[2*pos] < tree_min[2*pos+1]) ?
                         tree_min[2*pos] : tree_min[2*pos+1];
         tree_max[pos] = (tree_max[2*pos] > tree_max[2*pos+1]) ?
                         tree_max[2*pos] : tree_max[2*pos+1];
         pos = pos >> 1;
      end
   endfunction

   // bottom-up fold over the inclusive leaf range, last clamped to the leaf count
   function automatic extremes_type tree_range(input int lo, input int hi);
      extremes_type acc;
      int l;
      int r;
      acc.lo_val = VAL_MAX;
      acc.hi_val = '0;
      if (hi >= LEAVES) hi = LEAVES - 1;
      if (lo > hi) return acc;
      l = PAD_LEAVES + lo;
      r = PAD_LEAVES + hi + 1;
      while (l < r) begin
         if (l % 2 == 1) begin
            if (tree_min[l] < acc.lo_val) acc.lo_val = tree_min[l];
            if (tree_max[l] > acc.hi_val) acc.hi_val = tree_max[l];
            l++;
         end
         if (r % 2 == 1) begin
            r--;
            if (tree_min[r] < acc.lo_val) acc.lo_val = tree_min[r];
            if (tree_max[r] > acc.hi_val) acc.hi_val = tree_max[r];
         end
         l = l >> 1;
         r = r >> 1;
      end
      return acc;
   endfunction

   // update the predictor for an accepted item and queue what it should return
   function automatic void apply_op(input tree_op_type op, input bit typed,
                                    input extremes_type typed_val);
      extremes_type res;
      if (op.func == rmmt_pkg::FUNC_WRITE) begin
         n_writes++;
         if (int'(op.first) < LEAVES) tree_store(int'(op.first), op.value);
      end else begin
         n_queries++;
         if (op.first > op.last) n_empty++;
         res = tree_range(int'(op.first), int'(op.last));
         pending_extremes.push_back(typed ? typed_val : res);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                  input logic [VAL_W-1:0] got);
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // one item on the request channel, held until accepted
   task automatic send_op(input tree_op_type op, input bit typed,
                          input extremes_type typed_val);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op.func;
      req_tdata  <= {5'b0, op.value, op.last, op.first};
      do @(posedge clock); while (!req_tready);
      apply_op(op, typed, typed_val);
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // random value with the extremes and small numbers weighted in
   function automatic logic [VAL_W-1:0] random_value();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return VAL_MAX;
      if (pick <= 3) return VAL_W'($urandom_range(0, 255));
      return VAL_W'($urandom);
   endfunction

   // random item, mostly writes and queries around a busy region of leaves
   function automatic tree_op_type random_op(input int hot_base, input int hot_span);
      tree_op_type op;
      int pick;
      int lo;
      int hi;
      op.func  = ($urandom_range(0, 99) < 45) ? rmmt_pkg::FUNC_WRITE : rmmt_pkg::FUNC_QUERY;
      op.first = IDX_W'($urandom);
      op.last  = IDX_W'($urandom);
      op.value = VAL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (op.func == rmmt_pkg::FUNC_WRITE) begin
         if (pick < 70) op.first = IDX_W'(hot_base + $urandom_range(0, hot_span - 1));
         op.value = random_value();
      end else if (pick < 50) begin
         lo = hot_base + $urandom_range(0, hot_span - 1);
         hi = lo + $urandom_range(0, 31);
         if (hi > LEAVES - 1) hi = LEAVES - 1;
         op.first = IDX_W'(lo);
         op.last  = IDX_W'(hi);
      end else if (pick < 65) begin
         lo = $urandom_range(0, LEAVES - 1);
         hi = $urandom_range(lo, LEAVES - 1);
         op.first = IDX_W'(lo);
         op.last  = IDX_W'(hi);
      end else if (pick < 75) begin
         op.first = '0;
         op.last  = IDX_W'(LEAVES - 1);
      end else if (pick < 85) begin
         op.last = op.first;
      end else if (pick < 95) begin
         // empty range, first above last
         lo = $urandom_range(1, LEAVES - 1);
         op.first = IDX_W'(lo);
         op.last  = IDX_W'($urandom_range(0, lo - 1));
      end
      return op;
   endfunction

   // receiver readiness: open, random, or long blocks of stall
   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_span = $urandom_range(50, 300);
      end else begin
         rx_span--;
      end
      case (rx_mode)
         RX_OPEN: begin
            rsp_tready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (rx_hold == 0) begin
               rsp_tready <= ~rsp_tready;
               rx_hold = $urandom_range(1, 40);
            end else begin
               rx_hold--;
            end
         end
      endcase
   end

   // result checker against the oldest queued expectation
   always @(posedge clock) begin
      extremes_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_extremes.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_tdata[30:0]);
         end else begin
            want = pending_extremes.pop_front();
            n_checked++;
            if (rsp_tdata[30:0] !== want.lo_val)
               report_mismatch("span_min", want.lo_val, rsp_tdata[30:0]);
            if (rsp_tdata[61:31] !== want.hi_val)
               report_mismatch("span_max", want.hi_val, rsp_tdata[61:31]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_extremes.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // main sequence: reset, directed table, random bursts, drain
   initial begin
      tree_op_type  op;
      extremes_type typed_val;
      int burst_left;
      int hot_base;
      int hot_span;
      int pause_at;

      for (int k = 1; k < 2 * PAD_LEAVES; k++) begin
         tree_min[k] = VAL_MAX;
         tree_max[k] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         op.func  = directed_rows[i].func;
         op.first = directed_rows[i].first;
         op.last  = directed_rows[i].last;
         op.value = directed_rows[i].value;
         typed_val.lo_val = directed_rows[i].want_min;
         typed_val.hi_val = directed_rows[i].want_max;
         send_op(op, directed_rows[i].typed, typed_val);
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
      end

      // random part in bursts, the busy region moving now and then
      burst_left = 0;
      hot_base = 0;
      hot_span = 64;
      pause_at = $urandom_range(RANDOM_ITEMS / 3, 2 * RANDOM_ITEMS / 3);
      typed_val.lo_val = '0;
      typed_val.hi_val = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            hot_span = $urandom_range(8, 96);
            hot_base = $urandom_range(0, LEAVES - hot_span);
         end
         if (n == pause_at) begin
            // hold off until every outstanding result has come back
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_extremes.size() != 0) @(posedge clock);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 20));
         end
         burst_left--;
         send_op(random_op(hot_base, hot_span), 1'b0, typed_val);
      end

      // drain
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_extremes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d writes and %0d queries (%0d of them empty ranges)",
               n_writes, n_queries, n_empty);
      $display("%0d results compared, %0d mismatches, %0d cycles",
               n_checked, mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rmmt_pkg.sv
sv/rmmt_datapath.sv
sv/rmmt_ctrl.sv
sv/range_min_max_tree_core.sv
bench/testbench.sv
